[design/xmodem_crc_receiver_defines.svh]
// ---------------------------------------------------------------------------
// xmodem_crc_receiver_defines
// Assertion macros shared by the receiver RTL.
// ---------------------------------------------------------------------------
`ifndef XMODEM_CRC_RECEIVER_DEFINES_SVH
`define XMODEM_CRC_RECEIVER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define XCR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xcr assertion failed");

// Consequent holds in the cycle after the antecedent.
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xcr assertion failed");

`endif

[design/xcr_pkg.sv]
// ---------------------------------------------------------------------------
// xcr_pkg
// Types, codes and helper functions of the XMODEM-CRC receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package xcr_pkg;

   localparam int MAX_BLOCK_BYTES   = 1024;
   localparam int SMALL_BLOCK_BYTES = 128;
   localparam int STORE_AW          = $clog2(MAX_BLOCK_BYTES);

   localparam logic [10:0] BIG_SIZE   = 11'(MAX_BLOCK_BYTES);
   localparam logic [10:0] SMALL_SIZE = 11'(SMALL_BLOCK_BYTES);

   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] CHR_E = 8'h45;
   localparam logic [7:0] CHR_R = 8'h52;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0]  POLL_RESET  = 8'd67;
   localparam logic [7:0]  RETRY_RESET = 8'd10;
   localparam logic [23:0] IMAGE_RESET = 24'd1152000;

   localparam logic [1:0] ACT_POLL    = 2'd0;
   localparam logic [1:0] ACT_BYTE    = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;

   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_GROUP = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [1:0] CSR_POLL_CHAR   = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd1;
   localparam logic [1:0] CSR_IMAGE_BYTES = 2'd2;

   typedef enum logic [1:0] {MODE_IDLE, MODE_BODY, MODE_CAN, MODE_FLUSH} mode_type;
   typedef enum logic [1:0] {PEND_NAK, PEND_ACK, PEND_END, PEND_CANCEL} pend_type;
   typedef enum logic [1:0] {RPL_NONE, RPL_BYTE, RPL_CANCEL, RPL_END} reply_type;
   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_READ, ST_WAIT, ST_GROUP, ST_SEND
   } state_type;

   typedef struct packed {
      logic take;
      logic rd_issue;
      logic load_group;
      logic load_send;
   } cmd_type;

   typedef struct packed {
      logic      accepted;
      logic      out_free;
      logic      has_groups;
      logic      rd_last;
      logic      more_groups;
      reply_type reply;
      logic      send_last;
   } status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx;
   } send_item_type;

   function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
      end
      return x;
   endfunction

   function automatic logic [2:0] send_len(reply_type r);
      logic [2:0] n;
      case (r)
         RPL_CANCEL: n = 3'd7;
         RPL_END:    n = 3'd2;
         default:    n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic send_item_type send_item(reply_type r, logic [2:0] idx,
                                               logic [7:0] hold);
      send_item_type s;
      s.kind = KIND_TX;
      s.tx   = hold;
      case (r)
         RPL_CANCEL: begin
            case (idx)
               3'd0, 3'd1, 3'd2: s.tx = B_CAN;
               3'd3:             s.tx = CHR_E;
               3'd4, 3'd5:       s.tx = CHR_R;
               default:          s.tx = B_ACK;
            endcase
         end
         RPL_END: begin
            if (idx == 3'd0) begin
               s.tx = B_ACK;
            end else begin
               s.kind = KIND_DONE;
               s.tx   = 8'h00;
            end
         end
         default: s.tx = hold;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

[design/xcr_req_if.sv]
// ---------------------------------------------------------------------------
// xcr_req_if
// Event channel into the receiver: poll, received byte or timeout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface xcr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] byte_value;
   modport source (output valid, action, byte_value, input ready);
   modport sink   (input valid, action, byte_value, output ready);
endinterface
`default_nettype wire

[design/xcr_rsp_if.sv]
// ---------------------------------------------------------------------------
// xcr_rsp_if
// Result channel: transmit byte, memory write group or end of transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface xcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  tx_byte;
   logic [23:0] byte_offset;
   logic [3:0]  word_count;
   logic [63:0] data_a;
   logic [63:0] data_b;
   logic [63:0] data_c;
   logic [63:0] data_d;
   logic        last;
   modport source (output valid, kind, tx_byte, byte_offset, word_count,
                   data_a, data_b, data_c, data_d, last, input ready);
   modport sink   (input valid, kind, tx_byte, byte_offset, word_count,
                   data_a, data_b, data_c, data_d, last, output ready);
endinterface
`default_nettype wire

[design/xcr_csr_if.sv]
// ---------------------------------------------------------------------------
// xcr_csr_if
// Register write channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface xcr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/xcr_ram.sv]
// ---------------------------------------------------------------------------
// xcr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xcr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

[design/xcr_datapath.sv]
// ---------------------------------------------------------------------------
// xcr_datapath
// Protocol state, CRC check, block store, write-group assembly and the
// output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xcr_datapath (
   input  logic                clock,
   input  logic                reset,
   xcr_req_if.sink             req,
   xcr_rsp_if.source           rsp,
   xcr_csr_if.sink             csr,
   input  xcr_pkg::cmd_type    cmd,
   output xcr_pkg::status_type status
);
   import xcr_pkg::*;

   // configuration
   logic [7:0]  poll_char_ff, retry_limit_ff;
   logic [23:0] image_bytes_ff;

   // protocol state
   mode_type    mode_ff, mode_in;
   pend_type    pend_ff, pend_in;
   logic [10:0] body_count_ff, body_count_in;
   logic        block_large_ff, block_large_in;
   logic [7:0]  seq_ff, seq_in, comp_ff, comp_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  expected_ff, expected_in, retries_ff, retries_in;
   logic [23:0] delivered_ff, delivered_in;

   // plan for the accepted word
   reply_type   reply_ff, reply_in;
   logic [7:0]  tx_hold_ff, tx_hold_in;
   logic [8:0]  words_left_ff, words_left_in;
   logic [23:0] grp_offset_ff, grp_offset_in;
   logic [9:0]  grp_addr_ff, grp_addr_in;

   // group read and output
   logic [4:0]   rd_idx_ff;
   logic         cap_valid_ff;
   logic [4:0]   cap_idx_ff;
   logic [255:0] grp_data_ff;
   logic [7:0]   ram_rdata;
   logic [2:0]   send_idx_ff;
   logic         rsp_valid_ff;

   logic          accept;
   logic [10:0]   size, store_idx, count, next_count;
   logic [15:0]   crc_fed;
   logic [23:0]   room;
   logic [11:0]   count_rounded;
   logic          ram_we;
   logic [3:0]    wc;
   logic [5:0]    last_byte;
   logic [7:0]    retries_next;
   send_item_type item;

   assign accept    = req.valid && cmd.take;
   assign req.ready = cmd.take;
   assign csr.ready = 1'b1;

   assign size      = block_large_ff ? BIG_SIZE : SMALL_SIZE;
   assign store_idx = body_count_ff - 11'd2;
   assign crc_fed   = crc_byte(crc_ff, req.byte_value);
   assign room      = image_bytes_ff - delivered_ff;
   assign count     = (room > {13'd0, size}) ? size : room[10:0];
   assign count_rounded = {1'b0, count} + 12'd3;

   always_comb begin
      mode_in        = mode_ff;
      pend_in        = pend_ff;
      body_count_in  = body_count_ff;
      block_large_in = block_large_ff;
      seq_in         = seq_ff;
      comp_in        = comp_ff;
      crc_in         = crc_ff;
      expected_in    = expected_ff;
      retries_in     = retries_ff;
      delivered_in   = delivered_ff;
      reply_in       = reply_ff;
      tx_hold_in     = tx_hold_ff;
      words_left_in  = words_left_ff;
      grp_offset_in  = grp_offset_ff;
      grp_addr_in    = grp_addr_ff;
      ram_we         = 1'b0;
      next_count     = body_count_ff + 11'd1;
      retries_next   = retries_ff;
      if (accept) begin
         reply_in      = RPL_NONE;
         tx_hold_in    = B_ACK;
         words_left_in = '0;
         grp_offset_in = delivered_ff;
         grp_addr_in   = '0;
         case (req.action)
            ACT_POLL: begin
               reply_in   = RPL_BYTE;
               tx_hold_in = poll_char_ff;
            end
            ACT_BYTE: begin
               case (mode_ff)
                  MODE_IDLE: begin
                     if (req.byte_value == B_SOH || req.byte_value == B_STX) begin
                        block_large_in = (req.byte_value == B_STX);
                        body_count_in  = '0;
                        crc_in         = '0;
                        mode_in        = MODE_BODY;
                     end else if (req.byte_value == B_EOT) begin
                        mode_in      = MODE_FLUSH;
                        pend_in      = PEND_END;
                        expected_in  = 8'd1;
                        delivered_in = '0;
                     end else if (req.byte_value == B_CAN) begin
                        mode_in = MODE_CAN;
                     end
                  end
                  MODE_CAN: begin
                     if (req.byte_value == B_CAN) begin
                        mode_in      = MODE_FLUSH;
                        pend_in      = PEND_ACK;
                        expected_in  = 8'd1;
                        delivered_in = '0;
                     end else begin
                        mode_in = MODE_IDLE;
                     end
                  end
                  MODE_BODY: begin
                     if (body_count_ff == 11'd0) begin
                        seq_in = req.byte_value;
                     end else if (body_count_ff == 11'd1) begin
                        comp_in = req.byte_value;
                     end else begin
                        crc_in = crc_fed;
                        ram_we = (store_idx < size);
                     end
                     body_count_in = next_count;
                     if (next_count >= size + 11'd4) begin
                        if (seq_ff != ~comp_ff || crc_fed != 16'd0 ||
                            (seq_ff != expected_ff && seq_ff != expected_ff - 8'd1)) begin
                           mode_in = MODE_FLUSH;
                           pend_in = PEND_NAK;
                        end else begin
                           if (seq_ff == expected_ff) begin
                              // new block: plan the write-out and advance
                              if (delivered_ff < image_bytes_ff) begin
                                 words_left_in = count_rounded[10:2];
                                 delivered_in  = delivered_ff + {13'd0, count};
                              end
                              expected_in  = expected_ff + 8'd1;
                              retries_next = retry_limit_ff;
                           end else begin
                              retries_next = retries_ff - 8'd1;
                           end
                           retries_in = retries_next;
                           if (retries_next == 8'd0) begin
                              mode_in = MODE_FLUSH;
                              pend_in = PEND_CANCEL;
                           end else begin
                              mode_in  = MODE_IDLE;
                              reply_in = RPL_BYTE;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
            ACT_TIMEOUT: begin
               case (mode_ff)
                  MODE_BODY: begin
                     mode_in = MODE_FLUSH;
                     pend_in = PEND_NAK;
                  end
                  MODE_CAN: mode_in = MODE_IDLE;
                  MODE_FLUSH: begin
                     mode_in = MODE_IDLE;
                     case (pend_ff)
                        PEND_NAK: begin
                           reply_in   = RPL_BYTE;
                           tx_hold_in = B_NAK;
                        end
                        PEND_CANCEL: reply_in = RPL_CANCEL;
                        PEND_END:    reply_in = RPL_END;
                        default:     reply_in = RPL_BYTE;
                     endcase
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      // advance to the next write group as one is handed out
      if (cmd.load_group) begin
         words_left_in = words_left_ff - {5'd0, wc};
         grp_offset_in = grp_offset_ff + 24'd32;
         grp_addr_in   = grp_addr_ff + 10'd32;
      end
   end

   xcr_ram #(.WIDTH(8), .DEPTH(MAX_BLOCK_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (store_idx[STORE_AW-1:0]),
      .wr_data (req.byte_value),
      .rd_en   (cmd.rd_issue),
      .rd_addr (grp_addr_ff + {5'd0, rd_idx_ff}),
      .rd_data (ram_rdata)
   );

   assign wc        = (words_left_ff > 9'd8) ? 4'd8 : words_left_ff[3:0];
   assign last_byte = {wc, 2'b00} - 6'd1;
   assign item      = send_item(reply_ff, send_idx_ff, tx_hold_ff);

   assign status.accepted    = accept;
   assign status.out_free    = !rsp_valid_ff || rsp.ready;
   assign status.has_groups  = (words_left_ff != 9'd0);
   assign status.rd_last     = (rd_idx_ff == last_byte[4:0]);
   assign status.more_groups = (words_left_ff > 9'd8);
   assign status.reply       = reply_ff;
   assign status.send_last   = (send_idx_ff == send_len(reply_ff) - 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_char_ff   <= POLL_RESET;
         retry_limit_ff <= RETRY_RESET;
         image_bytes_ff <= IMAGE_RESET;
         mode_ff        <= MODE_IDLE;
         pend_ff        <= PEND_NAK;
         body_count_ff  <= '0;
         block_large_ff <= 1'b0;
         seq_ff         <= '0;
         comp_ff        <= '0;
         crc_ff         <= '0;
         expected_ff    <= 8'd1;
         retries_ff     <= RETRY_RESET;
         delivered_ff   <= '0;
         reply_ff       <= RPL_NONE;
         words_left_ff  <= '0;
         rd_idx_ff      <= '0;
         cap_valid_ff   <= 1'b0;
         send_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               CSR_POLL_CHAR:   poll_char_ff   <= csr.data[7:0];
               CSR_RETRY_LIMIT: retry_limit_ff <= csr.data[7:0];
               CSR_IMAGE_BYTES: image_bytes_ff <= csr.data;
               default: ;
            endcase
         end
         mode_ff        <= mode_in;
         pend_ff        <= pend_in;
         body_count_ff  <= body_count_in;
         block_large_ff <= block_large_in;
         seq_ff         <= seq_in;
         comp_ff        <= comp_in;
         crc_ff         <= crc_in;
         expected_ff    <= expected_in;
         retries_ff     <= retries_in;
         delivered_ff   <= delivered_in;
         reply_ff       <= reply_in;
         words_left_ff  <= words_left_in;
         cap_valid_ff   <= cmd.rd_issue;
         if (cmd.rd_issue) begin
            rd_idx_ff <= status.rd_last ? 5'd0 : rd_idx_ff + 5'd1;
         end
         if (cmd.load_send) begin
            send_idx_ff <= status.send_last ? 3'd0 : send_idx_ff + 3'd1;
         end
         if (cmd.load_group || cmd.load_send) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   logic [1:0]  kind_ff;
   logic [7:0]  tx_ff;
   logic [23:0] offset_ff;
   logic [3:0]  wc_ff;
   logic [255:0] data_ff;
   logic        last_ff;

   always_ff @(posedge clock) begin
      tx_hold_ff    <= tx_hold_in;
      grp_offset_ff <= grp_offset_in;
      grp_addr_ff   <= grp_addr_in;
      cap_idx_ff    <= rd_idx_ff;
      // clear the group buffer as its first byte is read
      if (cmd.rd_issue && rd_idx_ff == 5'd0) begin
         grp_data_ff <= '0;
      end
      if (cap_valid_ff) begin
         grp_data_ff[{cap_idx_ff, 3'b000} +: 8] <= ram_rdata;
      end
      if (cmd.load_group) begin
         kind_ff   <= KIND_GROUP;
         tx_ff     <= 8'h00;
         offset_ff <= grp_offset_ff;
         wc_ff     <= wc;
         data_ff   <= grp_data_ff;
         last_ff   <= !status.more_groups && reply_ff == RPL_NONE;
      end else if (cmd.load_send) begin
         kind_ff   <= item.kind;
         tx_ff     <= item.tx;
         offset_ff <= '0;
         wc_ff     <= '0;
         data_ff   <= '0;
         last_ff   <= status.send_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.tx_byte     = tx_ff;
   assign rsp.byte_offset = offset_ff;
   assign rsp.word_count  = wc_ff;
   assign rsp.data_a      = data_ff[63:0];
   assign rsp.data_b      = data_ff[127:64];
   assign rsp.data_c      = data_ff[191:128];
   assign rsp.data_d      = data_ff[255:192];
   assign rsp.last        = last_ff;
endmodule
`default_nettype wire

[design/xcr_controller.sv]
// ---------------------------------------------------------------------------
// xcr_controller
// Sequencer: takes one word, then reads out write groups and sends replies.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xcr_controller (
   input  logic                clock,
   input  logic                reset,
   input  xcr_pkg::status_type status,
   output xcr_pkg::cmd_type    cmd
);
   import xcr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.accepted) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.has_groups) begin
               state_in = ST_READ;
            end else if (status.reply != RPL_NONE) begin
               state_in = ST_SEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            if (status.rd_last) begin
               state_in = ST_WAIT;
            end
         end
         // let the last byte land in the group buffer
         ST_WAIT: state_in = ST_GROUP;
         ST_GROUP: begin
            if (status.out_free) begin
               cmd.load_group = 1'b1;
               if (status.more_groups) begin
                  state_in = ST_READ;
               end else if (status.reply != RPL_NONE) begin
                  state_in = ST_SEND;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.load_send = 1'b1;
               if (status.send_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[design/xmodem_crc_receiver.sv]
// ---------------------------------------------------------------------------
// xmodem_crc_receiver
// XMODEM receiver with CRC-16 and 1K blocks, driven by poll, byte and
// timeout events.
// ---------------------------------------------------------------------------
// One event word is taken at a time. A word that causes no write-out sends
// up to 7 reply bytes, and an output stall holds it. The word that completes
// a new block, while the image still has room, also reads the block back from
// the byte-wide block store into write groups, one byte a cycle while a group
// is read; it waits between groups while the output register is full.
// Results are held in an output register until taken.
`timescale 1ns / 1ps
`default_nettype none
`include "xmodem_crc_receiver_defines.svh"
module xmodem_crc_receiver (
   input  logic      clock,
   input  logic      reset,
   xcr_req_if.sink   req_ch,
   xcr_rsp_if.source rsp_ch,
   xcr_csr_if.sink   csr_ch
);
   import xcr_pkg::*;

   cmd_type    cmd;
   status_type status;

   xcr_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   xcr_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .csr    (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

   `XCR_ASSERT_IMPL(a_group_free, clock, reset, cmd.load_group, status.out_free)
   `XCR_ASSERT_IMPL(a_send_free, clock, reset, cmd.load_send, status.out_free)
   `XCR_ASSERT_IMPL(a_read_alone, clock, reset, cmd.rd_issue, !cmd.load_group && !cmd.load_send)
   `XCR_ASSERT_NEXT(a_one_word, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
endmodule
`default_nettype wire

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the XMODEM-CRC receiver. An in-bench model of the
// protocol predicts every reply byte, write group and end-of-transfer result
// from the accepted event words. The stimulus is mostly well-formed blocks
// with random data, mixed with bad, cut-off and repeated blocks, EOT, CAN and
// noise. Both channels stall at random, and the register settings vary.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   import xcr_pkg::*;

   // action code with no meaning: the block drops it
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]   kind;
      logic [7:0]   tx;
      logic [23:0]  offset;
      logic [3:0]   wc;
      logic [255:0] data;
      logic         last;
   } rsp_word_type;

   class xfer_scoreboard;
      logic [7:0]  poll_char, retry_limit;
      logic [23:0] image_bytes;
      mode_type    mode;
      pend_type    pend;
      logic [7:0]  store [MAX_BLOCK_BYTES];
      logic [10:0] body_count;
      logic        big_block;
      logic [7:0]  seq_num, seq_inv, next_block, retries;
      logic [15:0] crc;
      logic [23:0] delivered;
      rsp_word_type expected [$];
      int          errors;

      function new();
         poll_char   = POLL_RESET;
         retry_limit = RETRY_RESET;
         image_bytes = IMAGE_RESET;
         mode        = MODE_IDLE;
         pend        = PEND_NAK;
         body_count  = '0;
         big_block   = 1'b0;
         seq_num     = '0;
         seq_inv     = '0;
         crc         = '0;
         next_block  = 8'd1;
         retries     = RETRY_RESET;
         delivered   = '0;
         errors      = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [23:0] val);
         case (idx)
            CSR_POLL_CHAR:   poll_char   = val[7:0];
            CSR_RETRY_LIMIT: retry_limit = val[7:0];
            CSR_IMAGE_BYTES: image_bytes = val;
            default: ;
         endcase
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] tx, logic [23:0] off,
                         logic [3:0] wc, logic [255:0] data);
         rsp_word_type r;
         r.kind   = kind;
         r.tx     = tx;
         r.offset = off;
         r.wc     = wc;
         r.data   = data;
         r.last   = 1'b0;
         expected.push_back(r);
      endfunction

      function void emit_tx(logic [7:0] b);
         emit(KIND_TX, b, '0, '0, '0);
      endfunction

      function void write_groups();
         int size, count, words, wc, base;
         logic [255:0] grp;
         size = big_block ? MAX_BLOCK_BYTES : SMALL_BLOCK_BYTES;
         if (delivered >= image_bytes) return;
         count = int'(image_bytes) - int'(delivered);
         if (count > size) count = size;
         words = (count + 3) / 4;
         for (int g = 0; g * 8 < words; g++) begin
            wc  = (words - g * 8 > 8) ? 8 : words - g * 8;
            grp = '0;
            for (int k = 0; k < wc; k++) begin
               base = (g * 8 + k) * 4;
               grp[k*32 +: 32] = {store[base+3], store[base+2], store[base+1], store[base]};
            end
            emit(KIND_GROUP, '0, delivered + 24'(g * 32), 4'(wc), grp);
         end
         delivered = delivered + 24'(count);
      endfunction

      function void close_block();
         logic ok;
         ok = (seq_num == ~seq_inv) && (seq_num == next_block || seq_num == next_block - 8'd1)
              && crc == 16'h0000;
         if (!ok) begin
            mode = MODE_FLUSH;
            pend = PEND_NAK;
            return;
         end
         if (seq_num == next_block) begin
            write_groups();
            next_block = next_block + 8'd1;
            retries    = retry_limit;
         end else begin
            retries = retries - 8'd1;
         end
         if (retries == 8'd0) begin
            mode = MODE_FLUSH;
            pend = PEND_CANCEL;
         end else begin
            mode = MODE_IDLE;
            emit_tx(B_ACK);
         end
      endfunction

      function void restart(pend_type p);
         mode       = MODE_FLUSH;
         pend       = p;
         next_block = 8'd1;
         delivered  = '0;
      endfunction

      function void take_byte(logic [7:0] b);
         int size;
         logic [15:0] c;
         size = big_block ? MAX_BLOCK_BYTES : SMALL_BLOCK_BYTES;
         case (mode)
            MODE_IDLE: begin
               if (b == B_SOH || b == B_STX) begin
                  big_block  = (b == B_STX);
                  body_count = '0;
                  crc        = '0;
                  mode       = MODE_BODY;
               end else if (b == B_EOT) begin
                  restart(PEND_END);
               end else if (b == B_CAN) begin
                  mode = MODE_CAN;
               end
            end
            MODE_CAN: begin
               if (b == B_CAN) restart(PEND_ACK);
               else mode = MODE_IDLE;
            end
            MODE_BODY: begin
               if (body_count == 0) seq_num = b;
               else if (body_count == 1) seq_inv = b;
               else begin
                  if (body_count - 2 < size) store[body_count - 2] = b;
                  c = crc ^ {b, 8'h00};
                  repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
                  crc = c;
               end
               body_count = body_count + 11'd1;
               if (body_count >= size + 4) close_block();
            end
            default: ;
         endcase
      endfunction

      function void take_timeout();
         case (mode)
            MODE_BODY: begin
               mode = MODE_FLUSH;
               pend = PEND_NAK;
            end
            MODE_CAN: mode = MODE_IDLE;
            MODE_FLUSH: begin
               mode = MODE_IDLE;
               case (pend)
                  PEND_NAK: emit_tx(B_NAK);
                  PEND_CANCEL: begin
                     repeat (3) emit_tx(B_CAN);
                     emit_tx(CHR_E);
                     emit_tx(CHR_R);
                     emit_tx(CHR_R);
                     emit_tx(B_ACK);
                  end
                  default: begin
                     emit_tx(B_ACK);
                     if (pend == PEND_END) emit(KIND_DONE, '0, '0, '0, '0);
                  end
               endcase
            end
            default: ;
         endcase
      endfunction

      function void note_event(logic [1:0] act, logic [7:0] b);
         int before_n;
         before_n = expected.size();
         case (act)
            ACT_POLL:    emit_tx(poll_char);
            ACT_BYTE:    take_byte(b);
            ACT_TIMEOUT: take_timeout();
            default: ;
         endcase
         if (expected.size() > before_n) expected[expected.size() - 1].last = 1'b1;
      endfunction

      function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(rsp_word_type r);
         rsp_word_type e;
         if (expected.size() == 0) begin
            $error("unexpected result word: kind %0d tx %0h", r.kind, r.tx);
            errors++;
            return;
         end
         e = expected.pop_front();
         compare("kind", e.kind, r.kind);
         compare("tx_byte", e.tx, r.tx);
         compare("byte_offset", e.offset, r.offset);
         compare("word_count", e.wc, r.wc);
         compare("data_a", e.data[63:0], r.data[63:0]);
         compare("data_b", e.data[127:64], r.data[127:64]);
         compare("data_c", e.data[191:128], r.data[191:128]);
         compare("data_d", e.data[255:192], r.data[255:192]);
         compare("last", e.last, r.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   xcr_req_if req_ch ();
   xcr_rsp_if rsp_ch ();
   xcr_csr_if csr_ch ();

   xmodem_crc_receiver DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   xfer_scoreboard sb;
   int req_idle_pct;
   int rsp_idle_pct;
   int stall_left;
   int words_sent;
   int results_seen;
   int blocks_sent;
   logic [7:0] blk [MAX_BLOCK_BYTES];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver side: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result({rsp_ch.kind, rsp_ch.tx_byte, rsp_ch.byte_offset, rsp_ch.word_count,
                          rsp_ch.data_d, rsp_ch.data_c, rsp_ch.data_b, rsp_ch.data_a,
                          rsp_ch.last});
         results_seen++;
      end
   end

   // called at a rising edge; returns at the edge where the word is taken
   task automatic put_event(logic [1:0] act, logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.byte_value <= b;
      forever begin
         @(negedge clock);
         if (req_ch.ready) break;
         @(posedge clock);
      end
      sb.note_event(act, b);
      if (act != ACT_IGNORED) words_sent++;
      @(posedge clock);
   endtask

   task automatic put_byte(logic [7:0] b);
      put_event(ACT_BYTE, b);
   endtask

   // flaw: 0 none, 1 bad CRC, 2 bad complement, 3 out-of-order number, 4 cut off
   task automatic put_block(logic big, logic [7:0] num, int flaw);
      int size;
      logic [15:0] c;
      size = big ? MAX_BLOCK_BYTES : SMALL_BLOCK_BYTES;
      c = '0;
      for (int i = 0; i < size; i++) begin
         blk[i] = 8'($urandom);
         c = c ^ {blk[i], 8'h00};
         repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      if (flaw == 1) c[$urandom_range(15)] ^= 1'b1;
      if (flaw == 3) num = num + 8'd5;
      put_byte(big ? B_STX : B_SOH);
      put_byte(num);
      put_byte(flaw == 2 ? ~num ^ 8'h10 : ~num);
      for (int i = 0; i < size; i++) begin
         if (flaw == 4 && i == size / 2) begin
            put_event(ACT_TIMEOUT, '0);
            return;
         end
         put_byte(blk[i]);
      end
      put_byte(c[15:8]);
      put_byte(c[7:0]);
      blocks_sent++;
   endtask

   // called at a rising edge; leaves valid high, the caller drops it
   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      forever begin
         @(negedge clock);
         if (csr_ch.ready) break;
         @(posedge clock);
      end
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic random_traffic(int n_items, logic allow_big);
      int start, pick;
      start = words_sent;
      while (words_sent - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 52) begin
            put_block(allow_big && $urandom_range(7) == 0, sb.next_block, 0);
         end else if (pick < 62) begin
            put_block(1'b0, sb.next_block - 8'd1, 0);
         end else if (pick < 72) begin
            put_block(1'b0, sb.next_block, $urandom_range(1, 4));
            repeat ($urandom_range(2)) put_byte(8'($urandom));
            put_event(ACT_TIMEOUT, '0);
         end else if (pick < 76) begin
            put_byte(B_EOT);
            put_event(ACT_TIMEOUT, '0);
         end else if (pick < 80) begin
            put_byte(B_CAN);
            put_byte(B_CAN);
            put_event(ACT_TIMEOUT, '0);
         end else if (pick < 84) begin
            put_byte(B_CAN);
            put_byte(8'($urandom));
         end else if (pick < 90) begin
            put_event(ACT_POLL, 8'($urandom));
         end else if (pick < 94) begin
            put_event(ACT_TIMEOUT, 8'($urandom));
         end else begin
            put_event(2'($urandom_range(3)), 8'($urandom));
         end
      end
   endtask

   initial begin
      sb            = new();
      req_idle_pct  = 8;
      rsp_idle_pct  = 59;
      stall_left    = 0;
      words_sent    = 0;
      results_seen  = 0;
      blocks_sent   = 0;
      reset         = 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_POLL;
      req_ch.byte_value <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= CSR_POLL_CHAR;
      csr_ch.data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, special cases
      put_event(ACT_POLL, 8'hFF);
      put_event(ACT_IGNORED, 8'h00);
      put_event(ACT_TIMEOUT, 8'hFF);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(B_CAN);
      put_byte(B_SOH);
      put_byte(B_CAN);
      put_event(ACT_TIMEOUT, '0);
      put_byte(B_CAN);
      put_byte(B_CAN);
      put_event(ACT_POLL, '0);
      put_event(ACT_TIMEOUT, '0);
      put_byte(B_SOH);
      put_byte(8'h01);
      put_event(ACT_TIMEOUT, '0);
      put_event(ACT_TIMEOUT, '0);
      put_byte(B_EOT);
      put_byte(B_SOH);
      put_event(ACT_TIMEOUT, '0);
      // 1K block header, cut off early
      put_byte(B_STX);
      put_byte(8'h01);
      put_byte(8'hFE);
      put_byte(8'hAA);
      put_event(ACT_TIMEOUT, '0);
      put_event(ACT_TIMEOUT, '0);
      settle();

      // phase one: clipped image with a partial last word
      write_reg(CSR_POLL_CHAR, 24'd67);
      write_reg(CSR_RETRY_LIMIT, 24'd3);
      write_reg(CSR_IMAGE_BYTES, 24'd301);
      csr_ch.valid <= 1'b0;
      random_traffic(60, 1'b0);
      settle();

      // phase two: empty image, cancel on first repeat
      req_idle_pct = 59;
      rsp_idle_pct = 8;
      write_reg(CSR_POLL_CHAR, 24'd0);
      write_reg(CSR_RETRY_LIMIT, 24'd1);
      write_reg(CSR_IMAGE_BYTES, 24'd0);
      csr_ch.valid <= 1'b0;
      random_traffic(50, 1'b0);
      settle();

      // phase three: full-range settings, long output hold-off across a block
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(CSR_POLL_CHAR, 24'd255);
      write_reg(CSR_RETRY_LIMIT, 24'd255);
      write_reg(CSR_IMAGE_BYTES, 24'hFFFFFF);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
      stall_left = 400;
      @(posedge clock);
      put_block(1'b0, sb.next_block, 0);
      repeat (6) put_event(ACT_POLL, '0);
      random_traffic(30, 1'b0);
      settle();

      $display("Covered %0d event words and %0d result words, %0d complete blocks,",
               words_sent, results_seen, blocks_sent);
      $display("with bad, cut-off and repeated blocks, EOT, CAN and three settings.");
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (sb.expected.size() != 0) $error("%0d results never arrived", sb.expected.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
